// ----- src/utf8_indic_to_byte_transcoder_core_assert.svh -----
// Assertion macros shared by the transcoder RTL.
// Included by the top level; depends on nothing else.
`ifndef UTF8_INDIC_TO_BYTE_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_INDIC_TO_BYTE_TRANSCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UIT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/uit_pkg.sv -----
// Shared types, codes and glyph tables of the UTF-8 to code page transcoder.
// Used by every module of the block; depends on nothing.
package uit_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned ROM_IDX_W = 7;
   localparam int unsigned ROM_DEPTH = 128;

   localparam logic [BYTE_W-1:0] LEAD_INDIC  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_JOINER = 8'hE2;
   localparam logic [BYTE_W-1:0] BLK_DEVA_A  = 8'hA4;
   localparam logic [BYTE_W-1:0] BLK_DEVA_B  = 8'hA5;
   localparam logic [BYTE_W-1:0] BLK_BENG_A  = 8'hA6;
   localparam logic [BYTE_W-1:0] BLK_BENG_B  = 8'hA7;
   localparam logic [BYTE_W-1:0] BLK_SINH_A  = 8'hB6;
   localparam logic [BYTE_W-1:0] BLK_SINH_B  = 8'hB7;
   localparam logic [BYTE_W-1:0] OFS_FIRST   = 8'h80;
   localparam logic [BYTE_W-1:0] OFS_SECOND  = 8'h40;

   typedef enum logic [STATUS_W-1:0] {
      ST_EMIT     = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_STRAY    = 2'd2,
      ST_JOINER   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_SECOND = 2'd1,
      SEQ_THIRD  = 2'd2
   } seq_state_type;

   typedef enum logic [1:0] {
      TBL_NONE = 2'd0,
      TBL_DEVA = 2'd1,
      TBL_BENG = 2'd2,
      TBL_SINH = 2'd3
   } table_sel_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
   } result_type;

   localparam logic [BYTE_W-1:0] DEVA_ROM [ROM_DEPTH] = '{
      8'hf7,8'hf0,8'hf1,8'hf2,8'h80,8'h80,8'h88,8'h82,8'h8a,8'h83,8'h8b,8'h84,8'h85,8'ha6,8'h86,8'h86,
      8'h8e,8'ha7,8'h87,8'ha7,8'h8f,8'hb0,8'hc0,8'hb1,8'hc1,8'hbd,8'hb2,8'hc2,8'hb3,8'hc3,8'hcd,8'hb4,
      8'hc4,8'hb5,8'hc5,8'hc6,8'hb7,8'hc7,8'hb8,8'hc8,8'hb6,8'hb6,8'hb9,8'hc9,8'hba,8'hca,8'he2,8'hbf,
      8'hbe,8'hde,8'hbb,8'hcb,8'h00,8'he0,8'hcc,8'hdc,8'hbc,8'he1,8'h00,8'h00,8'hf6,8'hf8,8'h98,8'h92,
      8'h9a,8'h93,8'h9b,8'h94,8'h9c,8'hae,8'h96,8'h96,8'h9e,8'haf,8'h97,8'h97,8'h9f,8'hf5,8'h96,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'hae,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hd5,8'h00,8'h00,8'hdf,
      8'h8c,8'h8d,8'h95,8'h9d,8'hf9,8'hfa,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
   };

   localparam logic [BYTE_W-1:0] BENG_ROM [ROM_DEPTH] = '{
      8'h00,8'hf0,8'hf1,8'hf2,8'h00,8'h80,8'h88,8'h82,8'h8a,8'h83,8'h8b,8'h84,8'h85,8'h00,8'h00,8'h86,
      8'h8e,8'h00,8'h00,8'h87,8'h8f,8'hb0,8'hc0,8'hb1,8'hc1,8'hbd,8'hb2,8'hc2,8'hb3,8'hc3,8'hcd,8'hb4,
      8'hc4,8'hb5,8'hc5,8'hc6,8'hb7,8'hc7,8'hb8,8'hc8,8'hb6,8'h00,8'hb9,8'hc9,8'hba,8'hca,8'he2,8'hbf,
      8'hbe,8'h00,8'hbb,8'h00,8'h00,8'h00,8'hcc,8'hdc,8'hbc,8'he1,8'h00,8'h00,8'hf6,8'hf8,8'h98,8'h92,
      8'h9a,8'h93,8'h9b,8'h94,8'h9c,8'h00,8'h00,8'h96,8'h9e,8'h00,8'h00,8'h97,8'h9f,8'hf5,8'hb7,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h9f,8'h00,8'h00,8'h00,8'h00,8'hde,8'hce,8'h00,8'hdf,
      8'h8c,8'h8d,8'h95,8'h9d,8'hf9,8'hfa,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
      8'hbe,8'hbe,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hf1,8'h00,8'h00,8'h00
   };

   localparam logic [BYTE_W-1:0] SINH_ROM [ROM_DEPTH] = '{
      8'h00,8'h00,8'hf1,8'hf2,8'h00,8'h80,8'h88,8'h81,8'h89,8'h82,8'h8a,8'h83,8'h8b,8'h84,8'h8c,8'h85,
      8'h8d,8'h86,8'ha6,8'h81,8'h87,8'ha7,8'h8f,8'h00,8'h00,8'h00,8'hb0,8'hc0,8'hb1,8'hc1,8'hbd,8'hd1,
      8'hb2,8'hc2,8'hb3,8'hc3,8'h00,8'h00,8'h00,8'hb4,8'hc4,8'hb5,8'hc5,8'hc6,8'hbd,8'hb7,8'hc7,8'hb8,
      8'hc8,8'hb6,8'h00,8'h00,8'hb9,8'hc9,8'hba,8'hca,8'he2,8'h00,8'hbf,8'hbe,8'h00,8'hbb,8'h00,8'h00,
      8'he0,8'hcc,8'hdc,8'hbc,8'he1,8'hcb,8'h00,8'h00,8'h00,8'h00,8'hf5,8'h00,8'h00,8'h00,8'h00,8'h91,
      8'h99,8'h99,8'h92,8'h9a,8'h93,8'h00,8'h9b,8'h00,8'h94,8'h96,8'hae,8'h9e,8'h97,8'haf,8'h9f,8'h9f,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h9c,8'h9d,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
   };

endpackage

// ----- src/uit_glyph_lookup.sv -----
// Glyph lookup: picks a table from the block byte and reads it at the third byte.
// Depends on uit_pkg for the tables and block constants.
module uit_glyph_lookup (
   input  logic [uit_pkg::BYTE_W-1:0] block_byte,
   input  logic [uit_pkg::BYTE_W-1:0] third_byte,
   output logic [uit_pkg::BYTE_W-1:0] glyph
);

   uit_pkg::table_sel_type            sel;
   logic [uit_pkg::BYTE_W-1:0]        offset;
   logic [uit_pkg::BYTE_W-1:0]        idx;
   logic [uit_pkg::ROM_IDX_W-1:0]     rom_idx;

   always_comb begin
      sel    = uit_pkg::TBL_NONE;
      offset = uit_pkg::OFS_FIRST;
      case (block_byte)
         uit_pkg::BLK_DEVA_A: begin
            sel    = uit_pkg::TBL_DEVA;
            offset = uit_pkg::OFS_FIRST;
         end
         uit_pkg::BLK_DEVA_B: begin
            sel    = uit_pkg::TBL_DEVA;
            offset = uit_pkg::OFS_SECOND;
         end
         uit_pkg::BLK_BENG_A: begin
            sel    = uit_pkg::TBL_BENG;
            offset = uit_pkg::OFS_FIRST;
         end
         uit_pkg::BLK_BENG_B: begin
            sel    = uit_pkg::TBL_BENG;
            offset = uit_pkg::OFS_SECOND;
         end
         uit_pkg::BLK_SINH_A: begin
            sel    = uit_pkg::TBL_SINH;
            offset = uit_pkg::OFS_FIRST;
         end
         uit_pkg::BLK_SINH_B: begin
            sel    = uit_pkg::TBL_SINH;
            offset = uit_pkg::OFS_SECOND;
         end
         default: begin
            sel    = uit_pkg::TBL_NONE;
            offset = uit_pkg::OFS_FIRST;
         end
      endcase
   end

   assign idx     = third_byte - offset;
   assign rom_idx = idx[uit_pkg::ROM_IDX_W-1:0];

   // An index of 128 or more falls outside the table and reads as unmapped.
   always_comb begin
      glyph = '0;
      if (!idx[uit_pkg::BYTE_W-1]) begin
         case (sel)
            uit_pkg::TBL_DEVA: glyph = uit_pkg::DEVA_ROM[rom_idx];
            uit_pkg::TBL_BENG: glyph = uit_pkg::BENG_ROM[rom_idx];
            uit_pkg::TBL_SINH: glyph = uit_pkg::SINH_ROM[rom_idx];
            default:           glyph = '0;
         endcase
      end
   end

endmodule

// ----- src/uit_seq_ctl.sv -----
// Sequence tracker: holds the open multi-byte sequence and classifies each byte.
// Depends on uit_pkg and instantiates uit_glyph_lookup.
module uit_seq_ctl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [uit_pkg::BYTE_W-1:0] in_byte,
   output uit_pkg::result_type        result
);

   uit_pkg::seq_state_type      state_ff, state_in;
   logic                        joiner_ff, joiner_in;
   logic [uit_pkg::BYTE_W-1:0]  block_ff, block_in;
   logic [uit_pkg::BYTE_W-1:0]  glyph;

   uit_glyph_lookup u_lookup (
      .block_byte (block_ff),
      .third_byte (in_byte),
      .glyph      (glyph)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= uit_pkg::SEQ_IDLE;
         joiner_ff <= 1'b0;
         block_ff  <= '0;
      end else if (step) begin
         state_ff  <= state_in;
         joiner_ff <= joiner_in;
         block_ff  <= block_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      joiner_in       = joiner_ff;
      block_in        = block_ff;
      result.valid    = 1'b0;
      result.out_byte = '0;
      result.status   = uit_pkg::ST_EMIT;
      case (state_ff)
         uit_pkg::SEQ_SECOND: begin
            if (!joiner_ff) begin
               block_in = in_byte;
            end
            state_in = uit_pkg::SEQ_THIRD;
         end
         uit_pkg::SEQ_THIRD: begin
            state_in     = uit_pkg::SEQ_IDLE;
            result.valid = 1'b1;
            if (joiner_ff) begin
               joiner_in     = 1'b0;
               result.status = uit_pkg::ST_JOINER;
            end else begin
               result.out_byte = glyph;
               result.status   = (glyph != '0) ? uit_pkg::ST_EMIT : uit_pkg::ST_UNMAPPED;
            end
         end
         default: begin
            state_in = uit_pkg::SEQ_IDLE;
            if (!in_byte[uit_pkg::BYTE_W-1]) begin
               result.valid    = 1'b1;
               result.out_byte = in_byte;
            end else if (in_byte inside {uit_pkg::LEAD_INDIC, uit_pkg::LEAD_JOINER}) begin
               state_in  = uit_pkg::SEQ_SECOND;
               joiner_in = (in_byte == uit_pkg::LEAD_JOINER);
            end else begin
               result.valid  = 1'b1;
               result.status = uit_pkg::ST_STRAY;
            end
         end
      endcase
   end

endmodule

// ----- src/utf8_indic_to_byte_transcoder_core.sv -----
// Top level of the UTF-8 to single-byte code page transcoder.
// Depends on uit_pkg, uit_seq_ctl and the assertion macro header.
//
//   channel  direction  tdata            tuser
//   req      in         in_byte [7:0]    none
//   rsp      out        out_byte [7:0]   status [1:0]
//
// Each byte passes through the input register, each output word the result register.
// A new word is accepted every cycle unless rsp stalls; lead and second bytes yield no output.
// The input register advances whenever the result register is empty or being taken.
// Reset is synchronous and clears both valid flags and the open sequence.
`include "utf8_indic_to_byte_transcoder_core_assert.svh"

module utf8_indic_to_byte_transcoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [uit_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] in_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [uit_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic [uit_pkg::STATUS_W-1:0] rsp_tuser    // [1:0] status
);

   logic                        s1_valid_ff, s1_valid_in;
   logic [uit_pkg::BYTE_W-1:0]  s1_byte_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [uit_pkg::BYTE_W-1:0]  rsp_byte_ff;
   uit_pkg::status_type         rsp_status_ff;
   logic                        s1_adv;
   logic                        req_take;
   uit_pkg::result_type         result;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;

   uit_seq_ctl u_seq (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_adv),
      .in_byte (s1_byte_ff),
      .result  (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
      end
      if (s1_adv && result.valid) begin
         rsp_byte_ff   <= result.out_byte;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_status_ff;

   `UIT_ASSERT_NOW(a_nonemit_zero, clock, reset,
      rsp_tvalid && (rsp_tuser != uit_pkg::ST_EMIT), rsp_tdata == '0,
      "Output word with a non-emit status carries a nonzero byte.")
   `UIT_ASSERT_NEXT(a_s1_hold, clock, reset,
      s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_byte_ff),
      "Blocked input register lost or changed its word.")
   `UIT_ASSERT_NOW(a_ready_empty, clock, reset,
      !s1_valid_ff, req_tready,
      "Input not ready while the input register is empty.")
   `UIT_ASSERT_NEXT(a_result_loaded, clock, reset,
      s1_adv && result.valid, rsp_tvalid,
      "Result produced but result register not loaded.")

endmodule

// ----- bench/utf8_indic_to_byte_transcoder_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the UTF-8 to single-byte code page transcoder: a directed table,
// then random byte sequences, both sides idling at random, results checked against a predictor.
// Depends on uit_pkg and utf8_indic_to_byte_transcoder_core.
module utf8_indic_to_byte_transcoder_core_tb;
   import uit_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 1030;
   localparam int CALM_TAIL    = 150;

   typedef struct packed {
      logic [7:0] glyph;
      status_type status;
   } glyph_word_t;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        fixed;
      glyph_word_t word;
   } stim_row_t;

   localparam logic [0:127][7:0] DEVA_GLYPHS = {
      128'hf7f0f1f2808088828a838b8485a68686, 128'h8ea787a78fb0c0b1c1bdb2c2b3c3cdb4,
      128'hc4b5c5c6b7c7b8c8b6b6b9c9bacae2bf, 128'hbedebbcb00e0ccdcbce10000f6f89892,
      128'h9a939b949cae96969eaf97979ff59600, 128'h0000000000ae000000000000d50000df,
      128'h8c8d959df9fa00000000000000000000, 128'h00000000000000000000000000000000
   };
   localparam logic [0:127][7:0] BENG_GLYPHS = {
      128'h00f0f1f2008088828a838b8485000086, 128'h8e0000878fb0c0b1c1bdb2c2b3c3cdb4,
      128'hc4b5c5c6b7c7b8c8b600b9c9bacae2bf, 128'hbe00bb000000ccdcbce10000f6f89892,
      128'h9a939b949c0000969e0000979ff5b700, 128'h000000000000009f00000000dece00df,
      128'h8c8d959df9fa30313233343536373839, 128'hbebe00000000000000000000f1000000
   };
   localparam logic [0:127][7:0] SINH_GLYPHS = {
      128'h0000f1f20080888189828a838b848c85, 128'h8d86a68187a78f000000b0c0b1c1bdd1,
      128'hb2c2b3c3000000b4c4b5c5c6bdb7c7b8, 128'hc8b60000b9c9bacae200bfbe00bb0000,
      128'he0ccdcbce1cb00000000f50000000091, 128'h9999929a93009b009496ae9e97af9f9f,
      128'h00000000000000000000000000000000, 128'h00009c9d000000000000000000000000
   };

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   logic        row_fixed;
   glyph_word_t row_word;
   bit          idling;
   int          stall_left;
   int          error_count;
   int          bytes_in;
   int          status_seen [4];

   logic [1:0] seq_left;
   logic       seq_joiner;
   logic [7:0] seq_block;

   glyph_word_t pending_glyphs [$];
   logic [7:0]  byte_stream [$];

   stim_row_t directed_rows [23] = '{
      '{8'h00, 1'b1, '{8'h00, ST_EMIT}},
      '{8'h7F, 1'b1, '{8'h7F, ST_EMIT}},
      '{8'h80, 1'b1, '{8'h00, ST_STRAY}},
      '{8'hFF, 1'b1, '{8'h00, ST_STRAY}},
      '{8'hC2, 1'b1, '{8'h00, ST_STRAY}},
      '{8'hE0, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hA4, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h80, 1'b1, '{8'hF7, ST_EMIT}},
      '{8'hE0, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hB7, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hF3, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hE0, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hA6, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h00, 1'b1, '{8'h00, ST_UNMAPPED}},
      '{8'hE0, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h41, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h80, 1'b1, '{8'h00, ST_UNMAPPED}},
      '{8'hE2, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h41, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hFF, 1'b1, '{8'h00, ST_JOINER}},
      '{8'hE0, 1'b0, '{8'h00, ST_EMIT}},
      '{8'hA7, 1'b0, '{8'h00, ST_EMIT}},
      '{8'h7F, 1'b0, '{8'h00, ST_EMIT}}
   };

   utf8_indic_to_byte_transcoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser  (rsp_tuser)    // [1:0] status
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Advances the sequence state by one byte; returns 1 when the byte completes a word.
   function automatic bit transcode_byte(input logic [7:0] b, output glyph_word_t w);
      logic [0:127][7:0] tbl = '0;
      logic [7:0]        ofs = '0;
      logic [7:0]        idx;
      bit                known = 1'b1;
      w = '{8'h00, ST_EMIT};
      if (seq_left == 2'd2) begin
         if (!seq_joiner) seq_block = b;
         seq_left = 2'd1;
         return 1'b0;
      end
      if (seq_left == 2'd1) begin
         seq_left = 2'd0;
         if (seq_joiner) begin
            seq_joiner = 1'b0;
            w.status = ST_JOINER;
            return 1'b1;
         end
         case (seq_block)
            BLK_DEVA_A: begin tbl = DEVA_GLYPHS; ofs = OFS_FIRST; end
            BLK_DEVA_B: begin tbl = DEVA_GLYPHS; ofs = OFS_SECOND; end
            BLK_BENG_A: begin tbl = BENG_GLYPHS; ofs = OFS_FIRST; end
            BLK_BENG_B: begin tbl = BENG_GLYPHS; ofs = OFS_SECOND; end
            BLK_SINH_A: begin tbl = SINH_GLYPHS; ofs = OFS_FIRST; end
            BLK_SINH_B: begin tbl = SINH_GLYPHS; ofs = OFS_SECOND; end
            default: known = 1'b0;
         endcase
         idx = b - ofs;
         w.glyph = (known && !idx[7]) ? tbl[idx[6:0]] : 8'h00;
         w.status = (w.glyph != 8'h00) ? ST_EMIT : ST_UNMAPPED;
         return 1'b1;
      end
      seq_left = 2'd0;
      if (!b[7]) begin
         w.glyph = b;
         return 1'b1;
      end
      if (b == LEAD_INDIC || b == LEAD_JOINER) begin
         seq_left = 2'd2;
         seq_joiner = (b == LEAD_JOINER);
         return 1'b0;
      end
      w.status = ST_STRAY;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      glyph_word_t w;
      glyph_word_t got;
      glyph_word_t want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_in++;
            if (transcode_byte(req_tdata, w) || row_fixed) begin
               pending_glyphs.push_back(row_fixed ? row_word : w);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, status_type'(rsp_tuser)};
            status_seen[rsp_tuser]++;
            if (pending_glyphs.size() == 0) begin
               report_mismatch($sformatf("unexpected word glyph=%h status=%0d",
                                         got.glyph, got.status));
            end else begin
               want = pending_glyphs.pop_front();
               if (got.glyph !== want.glyph)
                  report_mismatch($sformatf("glyph expected %h got %h",
                                            want.glyph, got.glyph));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, got.status));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idling && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("utf8_indic_to_byte_transcoder_core_tb: errors");
      $finish;
   end

   task automatic send_word(input logic [7:0] b, input logic fixed, input glyph_word_t w);
      int gap;
      if (idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      row_fixed  <= fixed;
      row_word   <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] block_bytes [6];
      logic [7:0] blk;
      int         pick;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      rsp_tready  = 1'b0;
      row_fixed   = 1'b0;
      row_word    = '0;
      reset       = 1'b1;
      idling      = 1'b0;
      stall_left  = 0;
      error_count = 0;
      bytes_in    = 0;
      status_seen = '{0, 0, 0, 0};
      seq_left    = 2'd0;
      seq_joiner  = 1'b0;
      seq_block   = 8'h00;
      block_bytes = '{BLK_DEVA_A, BLK_DEVA_B, BLK_BENG_A, BLK_BENG_B, BLK_SINH_A, BLK_SINH_B};

      // Mostly well-formed sequences with random content, the rest noise.
      while (byte_stream.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            byte_stream.push_back(8'($urandom_range(0, 127)));
         end else if (pick < 75) begin
            blk = ($urandom_range(0, 99) < 85) ? block_bytes[$urandom_range(0, 5)]
                                                : 8'($urandom_range(0, 255));
            byte_stream.push_back(LEAD_INDIC);
            byte_stream.push_back(blk);
            if ($urandom_range(0, 9) < 7)
               byte_stream.push_back(blk[0] ? 8'($urandom_range(8'h40, 8'hBF))
                                            : 8'($urandom_range(8'h80, 8'hFF)));
            else
               byte_stream.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 87) begin
            byte_stream.push_back(LEAD_JOINER);
            byte_stream.push_back(8'($urandom_range(0, 255)));
            byte_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            byte_stream.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idling = 1'b1;

      foreach (directed_rows[i])
         send_word(directed_rows[i].in_byte, directed_rows[i].fixed, directed_rows[i].word);

      foreach (byte_stream[i]) begin
         if (i == byte_stream.size() / 2) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_glyphs.size() != 0);
         end
         if (i == byte_stream.size() - CALM_TAIL) idling = 1'b0;
         send_word(byte_stream[i], 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_glyphs.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("covered %0d input bytes in directed and random sequences with idling on both sides",
               bytes_in);
      $display("words seen: %0d glyphs, %0d unmapped, %0d stray, %0d joiners; %0d mismatches",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], error_count);
      if (error_count == 0 && pending_glyphs.size() == 0) begin
         $display("utf8_indic_to_byte_transcoder_core_tb: clean");
      end else begin
         $display("utf8_indic_to_byte_transcoder_core_tb: errors");
      end
      $finish;
   end

endmodule
